// ===== design/priority_message_queue_with_ack_timeout_assert.svh =====
// assertion macros for the priority message queue
// used by the top level, no other dependencies
`ifndef PRIORITY_MESSAGE_QUEUE_WITH_ACK_TIMEOUT_ASSERT_SVH
`define PRIORITY_MESSAGE_QUEUE_WITH_ACK_TIMEOUT_ASSERT_SVH

// same-cycle implication under reset
`define PMQ_ASSERT_HOLD(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under reset
`define PMQ_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/pmq_pkg.sv =====
// types and constants of the priority message queue
// no dependencies
`default_nettype none

package pmq_pkg;

	localparam int RING   = 32;
	localparam int RING_W = 5;

	localparam logic [31:0] LFSR_SEED = 32'h2545F491;
	localparam logic [31:0] LFSR_TAPS = 32'h80200003;

	// configuration register indexes
	localparam int CFG_AW = 3;
	localparam logic [CFG_AW-1:0] REG_LEVELS   = 3'd0;
	localparam logic [CFG_AW-1:0] REG_CAPACITY = 3'd1;
	localparam logic [CFG_AW-1:0] REG_ACK_TO   = 3'd2;
	localparam logic [CFG_AW-1:0] REG_RETRIES  = 3'd3;
	localparam logic [CFG_AW-1:0] REG_BOOST_TO = 3'd4;
	localparam logic [CFG_AW-1:0] REG_PERIOD   = 3'd5;

	typedef enum logic [2:0] {
		MODE_PUSH    = 3'd0,
		MODE_POP     = 3'd1,
		MODE_ACK     = 3'd2,
		MODE_ACK_POP = 3'd3,
		MODE_TICK    = 3'd4,
		MODE_COUNTS  = 3'd5,
		MODE_LIST    = 3'd6,
		MODE_ERASE   = 3'd7
	} mode_t;

	typedef enum logic [3:0] {
		ST_OK         = 4'd0,
		ST_BAD_PRI    = 4'd1,
		ST_DUPLICATE  = 4'd2,
		ST_FULL       = 4'd3,
		ST_NOT_FOUND  = 4'd4,
		ST_BAD_TOKEN  = 4'd5,
		ST_BAD_STATE  = 4'd6,
		ST_EMPTY      = 4'd7,
		ST_NOT_FAILED = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		PH_QUEUED  = 2'd0,
		PH_RUNNING = 2'd1,
		PH_DELAYED = 2'd2,
		PH_FAILED  = 2'd3
	} phase_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] msg_id;
		logic [3:0]  priority_req;
		logic [15:0] delay;
		logic [31:0] token;
		logic        requeue;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] out_id;
		logic [31:0] out_token;
		logic [5:0]  active_count;
		logic [5:0]  failed_count;
		logic [5:0]  free_count;
		logic        last;
	} out_item_t;

endpackage

`default_nettype wire

// ===== design/pmq_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module pmq_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== design/priority_message_queue_with_ack_timeout.sv =====
// priority message queue top level: slot table, level queues, sequencer
// depends on pmq_pkg, pmq_ram and the assertion macro header
//
//   port group   dir   handshake               payload
//   request      in    start && !busy          req (in_item_t)
//   result       out   done, one cycle pulse   rsp (out_item_t)
//   config       in    cfg_we                  cfg_addr, cfg_wdata
//
// push, ack and erase walk all slots; pop takes the head of the highest priority level
// tick walks all slots once, plus a second walk when a scan is due;
// each boost moves the queue entries behind the slot one at a time (read, then write)
// list failed walks all slots and gives one result per failed message, or one if none
// reset clears control state; results cannot be held off by the receiver
`default_nettype none
`include "priority_message_queue_with_ack_timeout_assert.svh"

module priority_message_queue_with_ack_timeout
	import pmq_pkg::*;
#(
	parameter int SLOTS     = 32,
	parameter int LEVELS    = 8,
	parameter int ID_BITS   = 16,
	parameter int TIME_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire in_item_t          req,
	output logic                   busy,
	output logic                   done,
	output out_item_t              rsp,
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [15:0]       cfg_wdata
);

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W  = SLOT_W + 1;
	localparam int LV_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int QAW    = LV_W + RING_W;
	localparam int QDEPTH = (1 << LV_W) * RING;

	typedef enum logic [17:0] {
		S_IDLE      = 18'b000000000000000001,
		S_FIND      = 18'b000000000000000010,
		S_DECIDE    = 18'b000000000000000100,
		S_INSTALL   = 18'b000000000000001000,
		S_ACKDO     = 18'b000000000000010000,
		S_ERASE     = 18'b000000000000100000,
		S_QPUSH     = 18'b000000000001000000,
		S_POP       = 18'b000000000010000000,
		S_POP_RD    = 18'b000000000100000000,
		S_POP_DO    = 18'b000000001000000000,
		S_POP_SET   = 18'b000000010000000000,
		S_TICK      = 18'b000000100000000000,
		S_SCAN      = 18'b000001000000000000,
		S_SCAN_NEXT = 18'b000010000000000000,
		S_REM_RD    = 18'b000100000000000000,
		S_REM_CHK   = 18'b001000000000000000,
		S_SH_RD     = 18'b010000000000000000,
		S_LIST      = 18'b100000000000000000,
		S_SH_WR     = 18'b000000000000000000,
		S_EMIT      = 18'b110000000000000000
	} state_t;

	typedef struct packed {
		logic                 we_init;
		logic                 we_phase;
		phase_t               phase;
		logic                 we_stamp;
		logic [TIME_BITS-1:0] stamp;
		logic                 we_tok;
		logic [31:0]          tok;
		logic                 we_fc;
		logic [7:0]           fc;
		logic                 we_boost;
		logic                 boost;
	} slot_wr_t;

	// configuration
	logic [3:0]  cfg_levels_q;
	logic [5:0]  cfg_cap_q;
	logic [15:0] cfg_ack_q;
	logic [7:0]  cfg_retries_q;
	logic [15:0] cfg_boost_q;
	logic [15:0] cfg_period_q;

	// slot table
	logic                 valid_q [SLOTS];
	logic [ID_BITS-1:0]   id_q    [SLOTS];
	logic [LV_W-1:0]      lvl_arr_q [SLOTS];
	phase_t               phase_q [SLOTS];
	logic [TIME_BITS-1:0] stamp_q [SLOTS];
	logic [7:0]           fc_q    [SLOTS];
	logic                 boost_q [SLOTS];
	logic [31:0]          tok_q   [SLOTS];

	// level queues
	logic [RING_W-1:0] head_q [LEVELS];
	logic [RING_W:0]   len_q  [LEVELS];

	// global state
	logic [TIME_BITS-1:0] now_q;
	logic [15:0]          pc_q;
	logic [31:0]          lfsr_q;
	logic [CNT_W-1:0]     queued_q;
	logic [CNT_W-1:0]     failed_q;
	logic [CNT_W-1:0]     held_q;

	// sequencer
	state_t            state_q;
	state_t            ret_q;
	in_item_t          item_q;
	logic [SLOT_W-1:0] sidx_q;
	logic [SLOT_W-1:0] fslot_q;
	logic [SLOT_W-1:0] free_q;
	logic              found_q;
	logic              ffree_q;
	logic [LV_W-1:0]   lvl_q;
	logic [RING_W:0]   k_q;
	logic              qinc_q;
	logic              scan_q;
	logic              pend_q;
	status_t           status_q;
	logic [15:0]       oid_q;
	logic [31:0]       otok_q;
	logic              done_q;
	out_item_t         rsp_q;

	// combinational
	logic                 cur_valid;
	logic [ID_BITS-1:0]   cur_id;
	logic [LV_W-1:0]      cur_lvl;
	phase_t               cur_phase;
	logic [TIME_BITS-1:0] cur_stamp;
	logic [7:0]           cur_fc;
	logic                 cur_boost;
	logic [31:0]          cur_tok;
	logic [47:0]          id_wide;
	logic [47:0]          cid_wide;
	logic [ID_BITS-1:0]   id_in;
	logic [15:0]          cur_id16;
	logic [TIME_BITS-1:0] age;
	logic [TIME_BITS-1:0] delay_stamp;
	logic                 dly_nz;
	logic                 tok_bad;
	logic [7:0]           fnew;
	logic                 to_hit;
	logic                 fail_hit;
	logic                 boost_hit;
	logic                 rel_hit;
	logic                 last_slot;
	logic [LV_W-1:0]      lsel;
	logic [RING_W-1:0]    head_sel;
	logic [RING_W:0]      len_sel;
	logic                 len_room;
	logic                 shift_more;
	logic [LV_W-1:0]      pick;
	logic                 pick_any;
	logic [3:0]           lv_eff;
	logic [CNT_W-1:0]     cap_eff;
	logic [15:0]          period_eff;
	logic [15:0]          pc_next;
	logic [31:0]          lfsr_next;
	logic [5:0]           active_cnt;
	logic [5:0]           free_cnt;
	logic [5:0]           failed_cnt;
	logic                 ram_we;
	logic [QAW-1:0]       ram_waddr;
	logic [SLOT_W-1:0]    ram_wdata;
	logic [QAW-1:0]       ram_raddr;
	logic [SLOT_W-1:0]    ram_rdata;
	slot_wr_t             sw;

	// effective configuration
	assign lv_eff     = (cfg_levels_q > 4'(LEVELS)) ? 4'(LEVELS) : cfg_levels_q;
	assign cap_eff    = (cfg_cap_q > 6'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(cfg_cap_q);
	assign period_eff = (cfg_period_q == 16'd0) ? 16'd1 : cfg_period_q;
	assign pc_next    = pc_q + 16'd1;
	assign lfsr_next  = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? LFSR_TAPS : 32'd0);

	// current slot read
	assign cur_valid = valid_q[sidx_q];
	assign cur_id    = id_q[sidx_q];
	assign cur_lvl   = lvl_arr_q[sidx_q];
	assign cur_phase = phase_q[sidx_q];
	assign cur_stamp = stamp_q[sidx_q];
	assign cur_fc    = fc_q[sidx_q];
	assign cur_boost = boost_q[sidx_q];
	assign cur_tok   = tok_q[sidx_q];

	assign id_wide  = 48'(item_q.msg_id);
	assign id_in    = id_wide[ID_BITS-1:0];
	assign cid_wide = 48'(cur_id);
	assign cur_id16 = cid_wide[15:0];

	// slot checks
	assign age         = now_q - cur_stamp;
	assign dly_nz      = item_q.delay != 16'd0;
	assign delay_stamp = now_q + TIME_BITS'(item_q.delay);
	assign tok_bad     = !(cur_phase == PH_RUNNING || cur_phase == PH_FAILED)
	                     || cur_tok != item_q.token;
	assign fnew        = (cur_fc == 8'hFF) ? 8'hFF : cur_fc + 8'd1;
	assign to_hit      = cur_valid && cur_phase == PH_RUNNING && cfg_ack_q != 16'd0
	                     && age > TIME_BITS'(cfg_ack_q);
	assign fail_hit    = cfg_retries_q != 8'd0 && fnew == cfg_retries_q;
	assign boost_hit   = cur_valid && cur_phase == PH_QUEUED && cur_lvl != '0 && !cur_boost
	                     && age > TIME_BITS'(cfg_boost_q);
	assign rel_hit     = cur_valid && cur_phase == PH_DELAYED && cur_stamp == now_q;
	assign last_slot   = sidx_q == SLOT_W'(SLOTS - 1);

	// level queue access
	assign lsel       = (state_q == S_TICK) ? cur_lvl : lvl_q;
	assign head_sel   = head_q[lsel];
	assign len_sel    = len_q[lsel];
	assign len_room   = len_sel < (RING_W + 1)'(RING);
	assign shift_more = (k_q + (RING_W + 1)'(1)) < len_sel;

	// highest priority non-empty level (lowest index)
	always_comb begin
		pick     = '0;
		pick_any = 1'b0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (len_q[l] != '0) begin
				pick     = LV_W'(l);
				pick_any = 1'b1;
			end
		end
	end

	// result counts
	assign active_cnt = (held_q >= failed_q) ? 6'(held_q - failed_q) : 6'd0;
	assign free_cnt   = (cap_eff > held_q) ? 6'(cap_eff - held_q) : 6'd0;
	assign failed_cnt = 6'(failed_q);

	// queue ram ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {lvl_q, head_sel + len_sel[RING_W-1:0]};
		ram_wdata = sidx_q;
		ram_raddr = {lvl_q, head_sel};
		case (state_q)
			S_QPUSH: begin
				ram_we = len_room;
			end
			S_TICK: begin
				ram_we    = rel_hit && len_room;
				ram_waddr = {cur_lvl, head_sel - RING_W'(1)};
			end
			S_SH_WR: begin
				ram_we    = 1'b1;
				ram_waddr = {lvl_q, head_sel + k_q[RING_W-1:0]};
				ram_wdata = ram_rdata;
			end
			S_REM_RD: begin
				ram_raddr = {lvl_q, head_sel + k_q[RING_W-1:0]};
			end
			S_SH_RD: begin
				ram_raddr = {lvl_q, head_sel + k_q[RING_W-1:0] + RING_W'(1)};
			end
			default: begin
			end
		endcase
	end

	pmq_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (QDEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// slot field writes
	always_comb begin
		sw = '0;
		case (state_q)
			S_INSTALL: begin
				sw.we_init  = 1'b1;
				sw.we_phase = 1'b1;
				sw.phase    = dly_nz ? PH_DELAYED : PH_QUEUED;
				sw.we_stamp = 1'b1;
				sw.stamp    = dly_nz ? delay_stamp : now_q;
				sw.we_tok   = 1'b1;
				sw.we_fc    = 1'b1;
				sw.we_boost = 1'b1;
			end
			S_ACKDO: begin
				if (!tok_bad && cur_phase == PH_RUNNING && item_q.requeue) begin
					sw.we_phase = 1'b1;
					sw.phase    = dly_nz ? PH_DELAYED : PH_QUEUED;
					sw.we_stamp = 1'b1;
					sw.stamp    = dly_nz ? delay_stamp : now_q;
					sw.we_tok   = 1'b1;
					sw.we_boost = 1'b1;
				end
			end
			S_POP_SET: begin
				sw.we_phase = 1'b1;
				sw.phase    = PH_RUNNING;
				sw.we_stamp = 1'b1;
				sw.stamp    = now_q;
				sw.we_tok   = 1'b1;
				sw.tok      = lfsr_q;
			end
			S_TICK: begin
				if (rel_hit) begin
					sw.we_phase = 1'b1;
					sw.phase    = PH_QUEUED;
					sw.we_stamp = 1'b1;
					sw.stamp    = now_q;
				end
			end
			S_SCAN: begin
				if (to_hit) begin
					sw.we_fc    = 1'b1;
					sw.fc       = fnew;
					sw.we_phase = 1'b1;
					sw.phase    = fail_hit ? PH_FAILED : PH_QUEUED;
					sw.we_tok   = !fail_hit;
				end
			end
			S_SH_RD: begin
				if (!shift_more) begin
					sw.we_boost = 1'b1;
					sw.boost    = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (sw.we_init) begin
			id_q[sidx_q]      <= id_in;
			lvl_arr_q[sidx_q] <= item_q.priority_req[LV_W-1:0];
		end
		if (sw.we_phase) begin
			phase_q[sidx_q] <= sw.phase;
		end
		if (sw.we_stamp) begin
			stamp_q[sidx_q] <= sw.stamp;
		end
		if (sw.we_tok) begin
			tok_q[sidx_q] <= sw.tok;
		end
		if (sw.we_fc) begin
			fc_q[sidx_q] <= sw.fc;
		end
		if (sw.we_boost) begin
			boost_q[sidx_q] <= sw.boost;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_levels_q  <= 4'd4;
			cfg_cap_q     <= 6'd32;
			cfg_ack_q     <= 16'd0;
			cfg_retries_q <= 8'd3;
			cfg_boost_q   <= 16'd1000;
			cfg_period_q  <= 16'd1;
			for (int s = 0; s < SLOTS; s++) begin
				valid_q[s] <= 1'b0;
			end
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l] <= '0;
				len_q[l]  <= '0;
			end
			now_q    <= '0;
			pc_q     <= '0;
			lfsr_q   <= LFSR_SEED;
			queued_q <= '0;
			failed_q <= '0;
			held_q   <= '0;
			state_q  <= S_IDLE;
			ret_q    <= S_EMIT;
			item_q   <= '0;
			sidx_q   <= '0;
			fslot_q  <= '0;
			free_q   <= '0;
			found_q  <= 1'b0;
			ffree_q  <= 1'b0;
			lvl_q    <= '0;
			k_q      <= '0;
			qinc_q   <= 1'b0;
			scan_q   <= 1'b0;
			pend_q   <= 1'b0;
			status_q <= ST_OK;
			oid_q    <= '0;
			otok_q   <= '0;
			done_q   <= 1'b0;
			rsp_q    <= '0;
		end else begin
			done_q <= 1'b0;

			// register writes
			if (cfg_we) begin
				case (cfg_addr)
					REG_LEVELS:   cfg_levels_q  <= cfg_wdata[3:0];
					REG_CAPACITY: cfg_cap_q     <= cfg_wdata[5:0];
					REG_ACK_TO:   cfg_ack_q     <= cfg_wdata;
					REG_RETRIES:  cfg_retries_q <= cfg_wdata[7:0];
					REG_BOOST_TO: cfg_boost_q   <= cfg_wdata;
					REG_PERIOD:   cfg_period_q  <= cfg_wdata;
					default: begin
					end
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						item_q   <= req;
						status_q <= ST_OK;
						oid_q    <= '0;
						otok_q   <= '0;
						sidx_q   <= '0;
						found_q  <= 1'b0;
						ffree_q  <= 1'b0;
						pend_q   <= 1'b0;
						case (req.mode)
							MODE_PUSH: begin
								if (req.priority_req >= lv_eff) begin
									status_q <= ST_BAD_PRI;
									state_q  <= S_EMIT;
								end else begin
									state_q <= S_FIND;
								end
							end
							MODE_POP: state_q <= S_POP;
							MODE_ACK, MODE_ACK_POP, MODE_ERASE: state_q <= S_FIND;
							MODE_TICK: begin
								now_q <= now_q + TIME_BITS'(1);
								if (pc_next >= period_eff) begin
									pc_q   <= '0;
									scan_q <= 1'b1;
								end else begin
									pc_q   <= pc_next;
									scan_q <= 1'b0;
								end
								state_q <= S_TICK;
							end
							MODE_LIST: begin
								status_q <= ST_EMPTY;
								state_q  <= S_LIST;
							end
							default: state_q <= S_EMIT;
						endcase
					end
				end

				// id lookup and first free slot
				S_FIND: begin
					if (cur_valid && cur_id == id_in) begin
						found_q <= 1'b1;
						fslot_q <= sidx_q;
					end
					if (!cur_valid && !ffree_q) begin
						ffree_q <= 1'b1;
						free_q  <= sidx_q;
					end
					if (last_slot) begin
						state_q <= S_DECIDE;
					end else begin
						sidx_q <= sidx_q + SLOT_W'(1);
					end
				end

				S_DECIDE: begin
					case (item_q.mode)
						MODE_PUSH: begin
							if (found_q) begin
								status_q <= ST_DUPLICATE;
								state_q  <= S_EMIT;
							end else if (held_q >= cap_eff || !ffree_q) begin
								status_q <= ST_FULL;
								state_q  <= S_EMIT;
							end else begin
								sidx_q  <= free_q;
								state_q <= S_INSTALL;
							end
						end
						MODE_ACK, MODE_ACK_POP, MODE_ERASE: begin
							if (!found_q) begin
								status_q <= ST_NOT_FOUND;
								state_q  <= S_EMIT;
							end else begin
								sidx_q  <= fslot_q;
								state_q <= (item_q.mode == MODE_ERASE) ? S_ERASE : S_ACKDO;
							end
						end
						default: state_q <= S_EMIT;
					endcase
				end

				S_INSTALL: begin
					valid_q[sidx_q] <= 1'b1;
					held_q          <= held_q + CNT_W'(1);
					if (dly_nz) begin
						state_q <= S_EMIT;
					end else begin
						lvl_q   <= item_q.priority_req[LV_W-1:0];
						qinc_q  <= 1'b1;
						ret_q   <= S_EMIT;
						state_q <= S_QPUSH;
					end
				end

				// ack checks: id found, then token, then state
				S_ACKDO: begin
					if (tok_bad) begin
						status_q <= ST_BAD_TOKEN;
						state_q  <= S_EMIT;
					end else if (cur_phase != PH_RUNNING) begin
						status_q <= ST_BAD_STATE;
						state_q  <= S_EMIT;
					end else if (item_q.requeue) begin
						if (dly_nz) begin
							state_q <= (item_q.mode == MODE_ACK_POP) ? S_POP : S_EMIT;
						end else begin
							lvl_q   <= cur_lvl;
							qinc_q  <= 1'b1;
							ret_q   <= (item_q.mode == MODE_ACK_POP) ? S_POP : S_EMIT;
							state_q <= S_QPUSH;
						end
					end else begin
						valid_q[sidx_q] <= 1'b0;
						held_q          <= held_q - CNT_W'(1);
						state_q <= (item_q.mode == MODE_ACK_POP) ? S_POP : S_EMIT;
					end
				end

				S_ERASE: begin
					if (cur_phase != PH_FAILED) begin
						status_q <= ST_NOT_FAILED;
					end else begin
						valid_q[sidx_q] <= 1'b0;
						held_q          <= held_q - CNT_W'(1);
						if (failed_q != '0) begin
							failed_q <= failed_q - CNT_W'(1);
						end
						oid_q <= cur_id16;
					end
					state_q <= S_EMIT;
				end

				// append slot at the tail of level lvl_q
				S_QPUSH: begin
					if (len_room) begin
						len_q[lvl_q] <= len_sel + (RING_W + 1)'(1);
					end
					if (qinc_q) begin
						queued_q <= queued_q + CNT_W'(1);
					end
					state_q <= ret_q;
				end

				// pop from highest priority non-empty level (lowest index)
				S_POP: begin
					if (queued_q == '0 || !pick_any) begin
						status_q <= ST_EMPTY;
						state_q  <= S_EMIT;
					end else begin
						lvl_q   <= pick;
						state_q <= S_POP_RD;
					end
				end

				S_POP_RD: state_q <= S_POP_DO;

				S_POP_DO: begin
					sidx_q       <= ram_rdata;
					head_q[lvl_q] <= head_sel + RING_W'(1);
					len_q[lvl_q]  <= len_sel - (RING_W + 1)'(1);
					lfsr_q       <= lfsr_next;
					queued_q     <= queued_q - CNT_W'(1);
					state_q      <= S_POP_SET;
				end

				S_POP_SET: begin
					status_q <= ST_OK;
					oid_q    <= cur_id16;
					otok_q   <= lfsr_q;
					state_q  <= S_EMIT;
				end

				// release due delayed messages onto the head of their level
				S_TICK: begin
					if (rel_hit) begin
						queued_q <= queued_q + CNT_W'(1);
						if (len_room) begin
							head_q[cur_lvl] <= head_sel - RING_W'(1);
							len_q[cur_lvl]  <= len_sel + (RING_W + 1)'(1);
						end
					end
					if (last_slot) begin
						sidx_q  <= '0;
						state_q <= scan_q ? S_SCAN : S_EMIT;
					end else begin
						sidx_q <= sidx_q + SLOT_W'(1);
					end
				end

				// monitor scan: timeouts and starvation boost
				S_SCAN: begin
					if (to_hit) begin
						if (fail_hit) begin
							failed_q <= failed_q + CNT_W'(1);
							if (last_slot) begin
								state_q <= S_EMIT;
							end else begin
								sidx_q <= sidx_q + SLOT_W'(1);
							end
						end else begin
							lvl_q   <= cur_lvl;
							qinc_q  <= 1'b1;
							ret_q   <= S_SCAN_NEXT;
							state_q <= S_QPUSH;
						end
					end else if (boost_hit) begin
						lvl_q   <= cur_lvl;
						k_q     <= '0;
						state_q <= S_REM_RD;
					end else if (last_slot) begin
						state_q <= S_EMIT;
					end else begin
						sidx_q <= sidx_q + SLOT_W'(1);
					end
				end

				S_SCAN_NEXT: begin
					if (last_slot) begin
						state_q <= S_EMIT;
					end else begin
						sidx_q  <= sidx_q + SLOT_W'(1);
						state_q <= S_SCAN;
					end
				end

				// search the level queue for the slot
				S_REM_RD: begin
					state_q <= (k_q >= len_sel) ? S_SCAN_NEXT : S_REM_CHK;
				end

				S_REM_CHK: begin
					if (ram_rdata == sidx_q) begin
						state_q <= S_SH_RD;
					end else begin
						k_q     <= k_q + (RING_W + 1)'(1);
						state_q <= S_REM_RD;
					end
				end

				// close the gap one entry at a time
				S_SH_RD: begin
					if (shift_more) begin
						state_q <= S_SH_WR;
					end else begin
						len_q[lvl_q] <= len_sel - (RING_W + 1)'(1);
						lvl_q        <= '0;
						qinc_q       <= 1'b0;
						ret_q        <= S_SCAN_NEXT;
						state_q      <= S_QPUSH;
					end
				end

				S_SH_WR: begin
					k_q     <= k_q + (RING_W + 1)'(1);
					state_q <= S_SH_RD;
				end

				// one result per failed slot, the pending one goes out when the next is seen
				S_LIST: begin
					if (cur_valid && cur_phase == PH_FAILED) begin
						if (pend_q) begin
							rsp_q  <= '{ST_OK, oid_q, 32'd0, active_cnt, failed_cnt, free_cnt,
							           1'b0};
							done_q <= 1'b1;
						end
						pend_q   <= 1'b1;
						oid_q    <= cur_id16;
						status_q <= ST_OK;
					end
					if (last_slot) begin
						state_q <= S_EMIT;
					end else begin
						sidx_q <= sidx_q + SLOT_W'(1);
					end
				end

				S_EMIT: begin
					rsp_q   <= '{status_q, oid_q, otok_q, active_cnt, failed_cnt, free_cnt, 1'b1};
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

	`PMQ_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "request accepted but block not busy")
	`PMQ_ASSERT_HOLD(a_last_idle, clk, arst_n, done && rsp.last, !busy, "final result while still busy")
	`PMQ_ASSERT_HOLD(a_more_busy, clk, arst_n, done && !rsp.last, busy, "partial result after sequencer stopped")
	`PMQ_ASSERT_HOLD(a_count_bound, clk, arst_n, 1'b1, failed_q <= held_q && queued_q <= held_q, "queued or failed count exceeds held count")

endmodule

`default_nettype wire
